>>> sv/tle_pkg.sv
// Shared types, character codes and echo expansion helpers for the line editor.
// No dependencies; used by tle_front, tle_cmd_fifo, tle_back and the top level.
package tle_pkg;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_FS    = 8'd28;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_AT    = 8'd64;
    localparam logic [7:0] CH_BSL   = 8'd92;
    localparam logic [7:0] CH_CARET = 8'd94;
    localparam logic [7:0] CH_DEL   = 8'd127;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_TAKE    = 1'b1;

    localparam logic [1:0] KIND_ECHO    = 2'd0;
    localparam logic [1:0] KIND_LINE    = 2'd1;
    localparam logic [1:0] KIND_NO_LINE = 2'd2;

    typedef enum logic [2:0] {
        CMD_CHAR,
        CMD_CARET,
        CMD_CRLF,
        CMD_ERASE3,
        CMD_ERASE6,
        CMD_DELIVER,
        CMD_NOLINE
    } cmd_code_t;

    // One unit of work for the back end: an echo sequence, a delivery or a no-line result.
    typedef struct packed {
        cmd_code_t  code;
        logic [7:0] data;
    } cmd_t;

    function automatic logic [2:0] beat_count(input cmd_code_t code);
        logic [2:0] n;
        unique case (code)
            CMD_CARET, CMD_CRLF: n = 3'd2;
            CMD_ERASE3:          n = 3'd3;
            CMD_ERASE6:          n = 3'd6;
            default:             n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] beat_byte(input cmd_code_t code, input logic [7:0] data,
                                             input logic [2:0] idx);
        logic [7:0] b;
        unique case (code)
            CMD_CARET:  b = (idx == 3'd0) ? CH_CARET : data;
            CMD_CRLF:   b = (idx == 3'd0) ? CH_CR : CH_LF;
            CMD_ERASE3: b = (idx == 3'd1) ? CH_SP : CH_BS;
            CMD_ERASE6: b = (idx == 3'd2 || idx == 3'd3) ? CH_SP : CH_BS;
            CMD_NOLINE: b = CH_NUL;
            default:    b = data;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] beat_kind(input cmd_code_t code);
        logic [1:0] k;
        unique case (code)
            CMD_DELIVER: k = KIND_LINE;
            CMD_NOLINE:  k = KIND_NO_LINE;
            default:     k = KIND_ECHO;
        endcase
        return k;
    endfunction

endpackage

>>> sv/tty_line_editor_echo.sv
// Terminal line editor with echo. The front end is full until an item is done:
// the accept edge reads the newest and oldest buffered bytes from the line memory,
// then execute edits the buffer and queues any command, waiting while the queue is
// full. The back end turns each command into one to six result beats, one per cycle
// while the output register is empty or popped; a two-entry command queue and the
// output register let input continue while results wait. Results are delivered in
// item order; the echo_enable register is written through its own valid/ready port.
// Depends on tle_pkg, tle_front, tle_cmd_fifo and tle_back.
module tty_line_editor_echo #(
    parameter int LINE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        operation,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        echo_enable
);

    tle_pkg::cmd_t  push_cmd;
    tle_pkg::cmd_t  head_cmd;
    logic           cmd_push;
    logic           cmd_full;
    logic           cmd_pop;
    logic           cmd_empty;

    assign cfg_ready = 1'b1;

    tle_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .rx_byte     (rx_byte),
        .cfg_valid   (cfg_valid),
        .echo_enable (echo_enable),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd         (push_cmd)
    );

    tle_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_cmd  (push_cmd),
        .q_full  (cmd_full),
        .rd_en   (cmd_pop),
        .rd_cmd  (head_cmd),
        .q_empty (cmd_empty)
    );

    tle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

>>> sv/tle_front.sv
// Front end: accepts items, owns the line buffer and its indices, classifies each
// item and issues echo, delivery and no-line commands. Depends on tle_pkg.
module tle_front #(
    parameter int LINE_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic            operation,
    input  logic [7:0]      rx_byte,
    input  logic            cfg_valid,
    input  logic            echo_enable,
    input  logic            cmd_full,
    output logic            cmd_push,
    output tle_pkg::cmd_t   cmd
);

    localparam int IW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(LINE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(LINE_DEPTH);

    typedef enum logic [1:0] {
        FS_IDLE = 2'b01,
        FS_EXEC = 2'b10
    } fstate_t;

    fstate_t        state_reg, state_next;
    logic           op_reg, op_next;
    logic [7:0]     byte_reg, byte_next;
    logic           echo_reg, echo_next;
    logic [IW-1:0]  write_index_reg, write_index_next;
    logic [IW-1:0]  read_index_reg, read_index_next;
    logic [CW-1:0]  fill_count_reg, fill_count_next;
    logic [CW-1:0]  newline_count_reg, newline_count_next;
    logic [7:0]     tail_data_reg;
    logic [7:0]     head_data_reg;

    logic [7:0]     line_mem [LINE_DEPTH];

    logic           accept;
    logic           fire;
    logic           need_cmd;
    logic           do_store;
    logic           do_take;
    logic           do_erase;
    logic           buf_full;
    logic [7:0]     ch;
    logic [IW-1:0]  tail_slot;
    logic [IW-1:0]  write_succ;
    logic [IW-1:0]  read_succ;
    tle_pkg::cmd_t  cmd_c;

    assign full   = (state_reg != FS_IDLE);
    assign accept = push && (state_reg == FS_IDLE);

    assign tail_slot  = (write_index_reg == '0) ? LAST_SLOT : write_index_reg - IW'(1);
    assign write_succ = (write_index_reg == LAST_SLOT) ? '0 : write_index_reg + IW'(1);
    assign read_succ  = (read_index_reg == LAST_SLOT) ? '0 : read_index_reg + IW'(1);
    assign buf_full   = (fill_count_reg == DEPTH_CNT);

    assign ch = (byte_reg == tle_pkg::CH_CR) ? tle_pkg::CH_LF : byte_reg;

    always_comb
    begin
        need_cmd   = 1'b0;
        do_store   = 1'b0;
        do_take    = 1'b0;
        do_erase   = 1'b0;
        cmd_c.code = tle_pkg::CMD_CHAR;
        cmd_c.data = ch;
        if (op_reg == tle_pkg::OP_TAKE)
        begin
            need_cmd = 1'b1;
            if (newline_count_reg == '0)
            begin
                cmd_c.code = tle_pkg::CMD_NOLINE;
                cmd_c.data = tle_pkg::CH_NUL;
            end
            else
            begin
                do_take    = 1'b1;
                cmd_c.code = tle_pkg::CMD_DELIVER;
                cmd_c.data = head_data_reg;
            end
        end
        else if (!echo_reg)
        begin
            do_store = 1'b1;
        end
        else if (ch == tle_pkg::CH_BS || ch == tle_pkg::CH_DEL)
        begin
            // never erase past a line end
            if (fill_count_reg != '0 && tail_data_reg != tle_pkg::CH_LF)
            begin
                do_erase   = 1'b1;
                need_cmd   = 1'b1;
                cmd_c.code = (tail_data_reg < tle_pkg::CH_SP) ? tle_pkg::CMD_ERASE6
                                                              : tle_pkg::CMD_ERASE3;
            end
        end
        else
        begin
            need_cmd = 1'b1;
            do_store = 1'b1;
            if (ch == tle_pkg::CH_LF)
            begin
                cmd_c.code = tle_pkg::CMD_CRLF;
            end
            else if (ch == tle_pkg::CH_NUL)
            begin
                cmd_c.code = tle_pkg::CMD_CARET;
                cmd_c.data = tle_pkg::CH_ZERO;
            end
            else if (ch == tle_pkg::CH_FS)
            begin
                cmd_c.code = tle_pkg::CMD_CARET;
                cmd_c.data = tle_pkg::CH_BSL;
            end
            else if (ch < tle_pkg::CH_SP)
            begin
                cmd_c.code = tle_pkg::CMD_CARET;
                cmd_c.data = tle_pkg::CH_AT + ch;
            end
        end
    end

    assign fire     = (state_reg == FS_EXEC) && (!need_cmd || !cmd_full);
    assign cmd_push = fire && need_cmd;
    assign cmd      = cmd_c;

    always_comb
    begin
        state_next         = state_reg;
        op_next            = op_reg;
        byte_next          = byte_reg;
        echo_next          = cfg_valid ? echo_enable : echo_reg;
        write_index_next   = write_index_reg;
        read_index_next    = read_index_reg;
        fill_count_next    = fill_count_reg;
        newline_count_next = newline_count_reg;
        if (accept)
        begin
            state_next = FS_EXEC;
            op_next    = operation;
            byte_next  = rx_byte;
        end
        if (fire)
        begin
            state_next = FS_IDLE;
            if (do_take)
            begin
                read_index_next = read_succ;
                fill_count_next = fill_count_reg - CW'(1);
                if (head_data_reg == tle_pkg::CH_LF)
                begin
                    newline_count_next = newline_count_reg - CW'(1);
                end
            end
            if (do_erase)
            begin
                write_index_next = tail_slot;
                fill_count_next  = fill_count_reg - CW'(1);
            end
            if (do_store && !buf_full)
            begin
                write_index_next = write_succ;
                fill_count_next  = fill_count_reg + CW'(1);
                if (ch == tle_pkg::CH_LF)
                begin
                    newline_count_next = newline_count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= FS_IDLE;
            echo_reg          <= 1'b1;
            write_index_reg   <= '0;
            read_index_reg    <= '0;
            fill_count_reg    <= '0;
            newline_count_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            echo_reg          <= echo_next;
            write_index_reg   <= write_index_next;
            read_index_reg    <= read_index_next;
            fill_count_reg    <= fill_count_next;
            newline_count_reg <= newline_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        byte_reg <= byte_next;
    end

    // Both candidate bytes are read on the accept edge and held for the execute state.
    always_ff @(posedge clk)
    begin
        if (fire && do_store && !buf_full)
        begin
            line_mem[write_index_reg] <= ch;
        end
        if (accept)
        begin
            tail_data_reg <= line_mem[tail_slot];
            head_data_reg <= line_mem[read_index_reg];
        end
    end

endmodule

>>> sv/tle_cmd_fifo.sv
// Two-entry command queue between the front and back ends.
// Depends on tle_pkg for the command type.
module tle_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  tle_pkg::cmd_t   wr_cmd,
    output logic            q_full,
    input  logic            rd_en,
    output tle_pkg::cmd_t   rd_cmd,
    output logic            q_empty
);

    tle_pkg::cmd_t  slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_wr;
    logic           do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign rd_cmd  = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

>>> sv/tle_back.sv
// Back end: expands each queued command into result beats, loaded one per cycle
// into the output register while it is empty or popped. Depends on tle_pkg.
module tle_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tle_pkg::cmd_t   head_cmd,
    input  logic            cmd_empty,
    output logic            cmd_pop,
    output logic            empty,
    input  logic            pop,
    output logic [1:0]      out_kind,
    output logic [7:0]      out_byte,
    output logic            last
);

    logic           out_valid_reg, out_valid_next;
    logic [1:0]     out_kind_reg, out_kind_next;
    logic [7:0]     out_byte_reg, out_byte_next;
    logic           out_last_reg, out_last_next;
    logic [2:0]     beat_idx_reg, beat_idx_next;
    logic           load;
    logic           final_beat;

    assign load       = (!out_valid_reg || pop) && !cmd_empty;
    assign final_beat = (beat_idx_reg == tle_pkg::beat_count(head_cmd.code) - 3'd1);
    assign cmd_pop    = load && final_beat;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        beat_idx_next  = beat_idx_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = tle_pkg::beat_kind(head_cmd.code);
            out_byte_next  = tle_pkg::beat_byte(head_cmd.code, head_cmd.data, beat_idx_reg);
            out_last_next  = final_beat;
            beat_idx_next  = final_beat ? 3'd0 : beat_idx_reg + 3'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            beat_idx_reg  <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            beat_idx_reg  <= beat_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign empty    = !out_valid_reg;
    assign out_kind = out_kind_reg;
    assign out_byte = out_byte_reg;
    assign last     = out_last_reg;

endmodule

>>> verif/tty_line_editor_echo_tb.sv
// Self-checking bench for tty_line_editor_echo: line editing, echo expansion,
// line delivery and the echo_enable register. Needs tle_pkg and the RTL only.
`timescale 1ns / 100ps

module tty_line_editor_echo_tb;

    localparam int LINE_DEPTH     = 64;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       fin;
    } beat_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       push        = 1'b0;
    logic       full;
    logic       operation   = tle_pkg::OP_RECEIVE;
    logic [7:0] rx_byte     = 8'h00;
    logic       empty;
    logic       pop         = 1'b0;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       last;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    logic       echo_enable = 1'b1;

    // shadow copy of the line buffer and the register
    logic [7:0]  line_mem [LINE_DEPTH];
    int unsigned wr_slot = 0;
    int unsigned rd_slot = 0;
    int unsigned held    = 0;
    int unsigned held_lf = 0;
    logic        echo_on = 1'b1;

    beat_t       beats_owed[$];
    int unsigned send_idle_pct = 0;
    int unsigned pop_stall_pct = 0;
    int unsigned failures      = 0;
    int unsigned items_sent    = 0;
    int unsigned takes_sent    = 0;
    int unsigned beats_checked = 0;
    int unsigned line_bytes    = 0;
    int unsigned quiet_cycles  = 0;

    tty_line_editor_echo #(
        .LINE_DEPTH(LINE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .operation(operation),
        .rx_byte(rx_byte),
        .empty(empty),
        .pop(pop),
        .out_kind(out_kind),
        .out_byte(out_byte),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .echo_enable(echo_enable)
    );

    always #5 clk = ~clk;

    function automatic beat_t make_beat(input logic [1:0] k, input logic [7:0] d);
        beat_t b;
        b.kind = k;
        b.data = d;
        b.fin  = 1'b0;
        return b;
    endfunction

    task automatic store_char(input logic [7:0] c);
        // a full buffer drops the byte
        if (held < LINE_DEPTH)
        begin
            line_mem[wr_slot] = c;
            wr_slot = (wr_slot + 1) % LINE_DEPTH;
            held++;
            if (c == tle_pkg::CH_LF)
                held_lf++;
        end
    endtask

    task automatic edit_line_and_echo(input logic op, input logic [7:0] rx);
        beat_t       seq[$];
        logic [7:0]  ch;
        logic [7:0]  prev;
        int unsigned slot;
        if (op == tle_pkg::OP_TAKE)
        begin
            if (held_lf == 0)
                seq.push_back(make_beat(tle_pkg::KIND_NO_LINE, tle_pkg::CH_NUL));
            else
            begin
                prev = line_mem[rd_slot];
                rd_slot = (rd_slot + 1) % LINE_DEPTH;
                held--;
                if (prev == tle_pkg::CH_LF)
                    held_lf--;
                seq.push_back(make_beat(tle_pkg::KIND_LINE, prev));
            end
        end
        else
        begin
            ch = (rx == tle_pkg::CH_CR) ? tle_pkg::CH_LF : rx;
            if (!echo_on)
                store_char(ch);
            else if (ch == tle_pkg::CH_BS || ch == tle_pkg::CH_DEL)
            begin
                slot = (wr_slot + LINE_DEPTH - 1) % LINE_DEPTH;
                // erase stops at a line end and on an empty buffer
                if (held != 0 && line_mem[slot] != tle_pkg::CH_LF)
                begin
                    prev = line_mem[slot];
                    wr_slot = slot;
                    held--;
                    seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_BS));
                    if (prev < tle_pkg::CH_SP)
                    begin
                        seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_BS));
                        seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_SP));
                        seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_SP));
                        seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_BS));
                        seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_BS));
                    end
                    else
                    begin
                        seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_SP));
                        seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_BS));
                    end
                end
            end
            else
            begin
                if (ch == tle_pkg::CH_LF)
                begin
                    seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_CR));
                    seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_LF));
                end
                else if (ch == tle_pkg::CH_NUL)
                begin
                    seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_CARET));
                    seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_ZERO));
                end
                else if (ch == tle_pkg::CH_FS)
                begin
                    seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_CARET));
                    seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_BSL));
                end
                else if (ch < tle_pkg::CH_SP)
                begin
                    seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_CARET));
                    seq.push_back(make_beat(tle_pkg::KIND_ECHO, tle_pkg::CH_AT + ch));
                end
                else
                    seq.push_back(make_beat(tle_pkg::KIND_ECHO, ch));
                store_char(ch);
            end
        end
        if (seq.size() != 0)
            seq[seq.size() - 1].fin = 1'b1;
        foreach (seq[i])
            beats_owed.push_back(seq[i]);
    endtask

    // Called at a falling edge; returns at the falling edge after the accept.
    // push stays high so back-to-back items need no second assignment.
    task automatic send_item(input logic op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        operation <= op;
        rx_byte   <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        edit_line_and_echo(op, b);
        items_sent++;
        if (op == tle_pkg::OP_TAKE)
            takes_sent++;
        @(negedge clk);
    endtask

    task automatic write_echo_enable(input logic val);
        push <= 1'b0;
        while (beats_owed.size() != 0)
            @(negedge clk);
        // silent items may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid   <= 1'b1;
        echo_enable <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        echo_on = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly typed lines followed by takes, with edits, controls and noise mixed in.
    task automatic pick_random_item(output logic op, output logic [7:0] ch);
        int unsigned roll;
        roll = $urandom_range(99);
        op   = tle_pkg::OP_RECEIVE;
        ch   = 8'($urandom_range(255, 0));
        if (held >= LINE_DEPTH - 4 && held_lf == 0)
            ch = echo_on ? tle_pkg::CH_BS : tle_pkg::CH_CR;   // keep the buffer from locking up
        else if (held_lf != 0 && roll < 40)
            op = tle_pkg::OP_TAKE;
        else if (roll < 70)
            ch = 8'($urandom_range(126, 32));
        else if (roll < 78)
            ch = 8'($urandom_range(31, 0));
        else if (roll < 86)
            ch = $urandom_range(1) ? tle_pkg::CH_BS : tle_pkg::CH_DEL;
        else if (roll < 93)
            ch = $urandom_range(1) ? tle_pkg::CH_CR : tle_pkg::CH_LF;
        else if (roll < 96)
            op = tle_pkg::OP_TAKE;
    endtask

    task automatic test_directed_echo();
        send_item(tle_pkg::OP_TAKE, 8'hFF);         // no line yet
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_BS);   // erase on empty buffer
        send_item(tle_pkg::OP_RECEIVE, 8'd65);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_NUL);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_FS);
        send_item(tle_pkg::OP_RECEIVE, 8'd1);
        send_item(tle_pkg::OP_RECEIVE, 8'd31);
        send_item(tle_pkg::OP_RECEIVE, 8'd255);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_SP);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_DEL);  // short erase
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_BS);   // short erase of a high byte
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_BS);   // long erase of a control
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_DEL);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_LF);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_BS);   // stops at the line end
        send_item(tle_pkg::OP_RECEIVE, 8'd122);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_CR);
        repeat (7) send_item(tle_pkg::OP_TAKE, 8'h00);
    endtask

    // Fills the buffer, then drains only part of the line so later phases
    // run against a nearly full buffer.
    task automatic test_line_overflow();
        send_idle_pct = 13;
        pop_stall_pct = 13;
        repeat (LINE_DEPTH) send_item(tle_pkg::OP_RECEIVE, 8'($urandom_range(126, 33)));
        send_item(tle_pkg::OP_RECEIVE, 8'($urandom_range(126, 33)));   // echoed, dropped
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_CR);                // echoed, dropped
        send_item(tle_pkg::OP_TAKE, 8'h00);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_BS);
        send_item(tle_pkg::OP_RECEIVE, 8'd1);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_DEL);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_CR);
        repeat (8) send_item(tle_pkg::OP_TAKE, 8'h00);
    endtask

    task automatic test_silent_store();
        send_idle_pct = 0;
        pop_stall_pct = 88;
        write_echo_enable(1'b0);
        send_item(tle_pkg::OP_RECEIVE, 8'd104);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_NUL);
        send_item(tle_pkg::OP_RECEIVE, 8'd255);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_BS);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_DEL);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_CR);
        send_item(tle_pkg::OP_RECEIVE, tle_pkg::CH_LF);
        repeat (4) send_item(tle_pkg::OP_TAKE, 8'h00);
        write_echo_enable(1'b1);
    endtask

    task automatic test_random_traffic();
        logic       op;
        logic [7:0] ch;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    pop_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 88;
                    pop_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    pop_stall_pct = 88;
                end
                default:
                begin
                    send_idle_pct = 13;
                    pop_stall_pct = 13;
                end
            endcase
            repeat (5)
            begin
                pick_random_item(op, ch);
                send_item(op, ch);
            end
        end
    endtask

    always @(negedge clk)
        pop <= ($urandom_range(99) >= pop_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (beats_owed.size() == 0)
            begin
                $error("result beat with nothing outstanding: kind %0d byte %0d last %0d",
                       out_kind, out_byte, last);
                failures++;
            end
            else
            begin
                beat_t want;
                want = beats_owed.pop_front();
                if (out_kind !== want.kind)
                begin
                    $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
                    failures++;
                end
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %0d, got %0d", want.data, out_byte);
                    failures++;
                end
                if (last !== want.fin)
                begin
                    $error("last: expected %0d, got %0d", want.fin, last);
                    failures++;
                end
                if (want.kind == tle_pkg::KIND_LINE)
                    line_bytes++;
                beats_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d beats outstanding",
                     quiet_cycles, beats_owed.size());
            $display("tty_line_editor_echo regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_echo();
        test_line_overflow();
        test_silent_store();
        test_random_traffic();
        push <= 1'b0;
        while (beats_owed.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("covered %0d items (%0d takes) with echo on and off, a full buffer and",
                 items_sent, takes_sent);
        $display("four stall mixes; %0d result beats checked, %0d of them line bytes",
                 beats_checked, line_bytes);
        if (failures == 0)
            $display("tty_line_editor_echo regression: pass");
        else
            $display("tty_line_editor_echo regression: fail");
        $finish;
    end

endmodule
